// File: rtl/golden_section_line_search_top_macros.svh
// assertion macros shared by the checker
`ifndef GOLDEN_SECTION_LINE_SEARCH_TOP_MACROS_SVH
`define GOLDEN_SECTION_LINE_SEARCH_TOP_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define GSS_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gss check failed");

// next-cycle implication, disabled while rst_n is low
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gss check failed");

`endif

// File: rtl/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants of the golden-section line search controller.
// ----------------------------------------------------------------------------
package gss_pkg;

    // golden factor (sqrt(5)-1)/2 as unsigned Q0.32, rounded to nearest
    localparam int unsigned     PSI_W   = 32;
    localparam logic [PSI_W-1:0] PSI_Q32 = 32'h9E3779B9;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd3;

    localparam int unsigned LIMIT_RESET = 100;

    // input request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;

    // result kinds
    localparam logic RES_PROBE = 1'b0;
    localparam logic RES_FINAL = 1'b1;

    // probe awaited in an iteration
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_SECOND = 4'b0100,
        PH_ITER   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic emit;
        logic kind;
    } t_step_status;

endpackage

// File: rtl/gss_cfg_regs.sv
// ----------------------------------------------------------------------------
// gss_cfg_regs
// Configuration register file: bounds, tolerance and iteration limit.
// ----------------------------------------------------------------------------
module gss_cfg_regs #(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 16,
    parameter int CFG_WIDTH   = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [gss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_WIDTH-1:0]             i_cfg_data,
    output logic signed [DATA_WIDTH-1:0]     o_lower,
    output logic signed [DATA_WIDTH-1:0]     o_upper,
    output logic [DATA_WIDTH-2:0]            o_tol,
    output logic [COUNT_WIDTH-1:0]           o_limit
);
    import gss_pkg::*;

    // one in fixed point, and about a thousandth of it
    localparam longint ONE_RESET = longint'(1) << FRAC_BITS;
    localparam longint TOL_RESET = (ONE_RESET + 500) / 1000;

    logic signed [DATA_WIDTH-1:0] r_lower;
    logic signed [DATA_WIDTH-1:0] r_upper;
    logic [DATA_WIDTH-2:0]        r_tol;
    logic [COUNT_WIDTH-1:0]       r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= DATA_WIDTH'(ONE_RESET);
            r_tol   <= (DATA_WIDTH-1)'(TOL_RESET);
            r_limit <= COUNT_WIDTH'(LIMIT_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOWER: r_lower <= i_cfg_data[DATA_WIDTH-1:0];
                CFG_UPPER: r_upper <= i_cfg_data[DATA_WIDTH-1:0];
                CFG_TOL:   r_tol   <= i_cfg_data[DATA_WIDTH-2:0];
                CFG_LIMIT: r_limit <= i_cfg_data[COUNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_lower = r_lower;
    assign o_upper = r_upper;
    assign o_tol   = r_tol;
    assign o_limit = r_limit;

endmodule

// File: rtl/gss_core.sv
// ----------------------------------------------------------------------------
// gss_core
// Search state and at most one narrowing step per registered input transaction.
// ----------------------------------------------------------------------------
module gss_core #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_kind,
    input  logic signed [DATA_WIDTH-1:0]  i_f,
    input  logic signed [DATA_WIDTH-1:0]  i_lower,
    input  logic signed [DATA_WIDTH-1:0]  i_upper,
    input  logic [DATA_WIDTH-2:0]         i_tol,
    input  logic [COUNT_WIDTH-1:0]        i_limit,
    output gss_pkg::t_step_status         o_status,
    output logic [DATA_WIDTH-1:0]         o_point,
    output logic [DATA_WIDTH-1:0]         o_width,
    output logic [COUNT_WIDTH-1:0]        o_steps,
    output logic [COUNT_WIDTH:0]          o_evals
);
    import gss_pkg::*;

    localparam int PROD_W = DATA_WIDTH + PSI_W;

    logic [DATA_WIDTH-1:0] r_low, r_high, r_left, r_right, r_lval, r_rval;
    logic [DATA_WIDTH-1:0] n_low, n_high, n_left, n_right, n_lval, n_rval;
    logic [COUNT_WIDTH-1:0] r_step, n_step;
    logic [COUNT_WIDTH:0]   r_eval, n_eval;
    t_phase                 r_phase, n_phase;
    logic                   r_pend, n_pend;

    logic                  w_is_start, w_swap, w_gt, w_stop;
    logic [DATA_WIDTH-1:0] w_lo_b, w_hi_b, w_start_span, w_adv_span, w_d;
    logic [DATA_WIDTH-1:0] w_lval_new, w_rval_new, w_mul_a, w_t;
    logic [DATA_WIDTH-1:0] w_sub_base, w_add_base, w_left_c, w_right_c, w_mid;
    logic [COUNT_WIDTH-1:0] w_step_new;
    logic [COUNT_WIDTH:0]   w_eval_new;
    logic [PROD_W-1:0]      w_prod;

    assign w_is_start   = (i_kind == REQ_START);
    assign w_swap       = (i_lower > i_upper);
    assign w_lo_b       = w_swap ? i_upper : i_lower;
    assign w_hi_b       = w_swap ? i_lower : i_upper;
    assign w_start_span = w_hi_b - w_lo_b;
    assign w_d          = r_high - r_low;
    assign w_mid        = r_low + (w_d >> 1);

    // values and counters after taking in the returned objective value
    assign w_lval_new = (r_phase == PH_ITER && r_pend == SIDE_LEFT) ? i_f : r_lval;
    assign w_rval_new = (r_phase == PH_SECOND ||
                         (r_phase == PH_ITER && r_pend == SIDE_RIGHT)) ? i_f : r_rval;
    assign w_step_new = (r_phase == PH_ITER) ? r_step + COUNT_WIDTH'(1) : r_step;
    assign w_eval_new = (r_phase == PH_SECOND) ? (COUNT_WIDTH+1)'(2)
                                               : r_eval + (COUNT_WIDTH+1)'(1);

    assign w_gt   = ($signed(w_lval_new) > $signed(w_rval_new));
    assign w_stop = (w_step_new == i_limit) || (w_d <= {i_tol, 1'b0});

    // width of the interval that survives the step
    assign w_adv_span = w_gt ? (r_high - r_left) : (r_right - r_low);

    // one shared golden scale: floor(span * psi)
    assign w_mul_a = w_is_start ? w_start_span : w_adv_span;
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(PSI_Q32);
    assign w_t     = w_prod[PROD_W-1:PSI_W];

    assign w_sub_base = w_is_start ? w_hi_b : r_right;
    assign w_add_base = w_is_start ? w_lo_b : r_left;
    assign w_left_c   = w_sub_base - w_t;
    assign w_right_c  = w_add_base + w_t;

    always_comb begin
        n_low    = r_low;
        n_high   = r_high;
        n_left   = r_left;
        n_right  = r_right;
        n_lval   = r_lval;
        n_rval   = r_rval;
        n_step   = r_step;
        n_eval   = r_eval;
        n_phase  = r_phase;
        n_pend   = r_pend;
        o_status = '{emit: 1'b0, kind: RES_PROBE};
        o_point  = '0;
        o_width  = '0;
        o_steps  = '0;
        o_evals  = '0;
        if (w_is_start) begin
            n_low    = w_lo_b;
            n_high   = w_hi_b;
            n_left   = w_left_c;
            n_right  = w_right_c;
            n_lval   = '0;
            n_rval   = '0;
            n_step   = '0;
            n_eval   = '0;
            n_pend   = SIDE_LEFT;
            n_phase  = PH_FIRST;
            o_status = '{emit: 1'b1, kind: RES_PROBE};
            o_point  = w_left_c;
        end else begin
            unique case (r_phase) inside
                PH_IDLE: ;
                PH_FIRST: begin
                    n_lval   = i_f;
                    n_eval   = (COUNT_WIDTH+1)'(1);
                    n_phase  = PH_SECOND;
                    o_status = '{emit: 1'b1, kind: RES_PROBE};
                    o_point  = r_right;
                end
                PH_SECOND, PH_ITER: begin
                    n_lval   = w_lval_new;
                    n_rval   = w_rval_new;
                    n_step   = w_step_new;
                    n_eval   = w_eval_new;
                    o_status = '{emit: 1'b1, kind: RES_PROBE};
                    if (w_stop) begin
                        n_phase  = PH_IDLE;
                        o_status = '{emit: 1'b1, kind: RES_FINAL};
                        o_point  = w_mid;
                        o_width  = w_d;
                        o_steps  = w_step_new;
                        o_evals  = w_eval_new;
                    end else if (w_gt) begin
                        // minimum lies right of the left probe
                        n_low   = r_left;
                        n_left  = r_right;
                        n_lval  = w_rval_new;
                        n_right = w_right_c;
                        n_pend  = SIDE_RIGHT;
                        n_phase = PH_ITER;
                        o_point = w_right_c;
                    end else begin
                        n_high  = r_right;
                        n_right = r_left;
                        n_rval  = w_lval_new;
                        n_left  = w_left_c;
                        n_pend  = SIDE_LEFT;
                        n_phase = PH_ITER;
                        o_point = w_left_c;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_lval  <= '0;
            r_rval  <= '0;
            r_step  <= '0;
            r_eval  <= '0;
            r_phase <= PH_IDLE;
            r_pend  <= SIDE_LEFT;
        end else if (i_fire) begin
            r_low   <= n_low;
            r_high  <= n_high;
            r_left  <= n_left;
            r_right <= n_right;
            r_lval  <= n_lval;
            r_rval  <= n_rval;
            r_step  <= n_step;
            r_eval  <= n_eval;
            r_phase <= n_phase;
            r_pend  <= n_pend;
        end
    end

endmodule

// File: rtl/golden_section_line_search_top.sv
// throughput: one input transaction per cycle unless the result stream stalls; each
//   pass goes through one DATA_WIDTH x 32 golden-scale multiplier between the input
//   and result registers
// reset: synchronous, active low; clears the search to idle and loads the
//   register defaults (bounds 0 and 1.0, tolerance about 0.001, limit 100)
// ----------------------------------------------------------------------------
// golden_section_line_search_top
// Golden-section minimiser controller with stream input and result channels.
// ----------------------------------------------------------------------------
module golden_section_line_search_top #(
    parameter int DATA_WIDTH  = 32,
    parameter int FRAC_BITS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [((DATA_WIDTH > COUNT_WIDTH) ? DATA_WIDTH : COUNT_WIDTH)-1:0] i_cfg_data,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: f_value
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // tuser: req_type
    input  logic                          i_s_tuser,
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: point_out, width_out, steps_done, evals_done, zero pad
    output logic [((2*DATA_WIDTH+2*COUNT_WIDTH+1+7)/8)*8-1:0] o_m_tdata,
    // tuser: result_kind
    output logic                          o_m_tuser
);
    import gss_pkg::*;

    localparam int CFG_WIDTH = (DATA_WIDTH > COUNT_WIDTH) ? DATA_WIDTH : COUNT_WIDTH;
    localparam int FIELDS_W  = 2*DATA_WIDTH + 2*COUNT_WIDTH + 1;
    localparam int OUT_W     = ((FIELDS_W + 7) / 8) * 8;

    logic signed [DATA_WIDTH-1:0] w_lower, w_upper;
    logic [DATA_WIDTH-2:0]        w_tol;
    logic [COUNT_WIDTH-1:0]       w_limit;

    logic                  r_in_valid, r_in_kind;
    logic [DATA_WIDTH-1:0] r_in_f;
    logic                  w_fire;

    t_step_status           w_status;
    logic [DATA_WIDTH-1:0]  w_point, w_width;
    logic [COUNT_WIDTH-1:0] w_steps;
    logic [COUNT_WIDTH:0]   w_evals;

    logic                   r_out_valid, r_out_kind;
    logic [DATA_WIDTH-1:0]  r_out_point, r_out_width;
    logic [COUNT_WIDTH-1:0] r_out_steps;
    logic [COUNT_WIDTH:0]   r_out_evals;

    assign o_cfg_ready = 1'b1;

    gss_cfg_regs #(
        .DATA_WIDTH  (DATA_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_lower     (w_lower),
        .o_upper     (w_upper),
        .o_tol       (w_tol),
        .o_limit     (w_limit)
    );

    // registered transaction moves on once the result slot is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind <= i_s_tuser;
            r_in_f    <= i_s_tdata[DATA_WIDTH-1:0];
        end
    end

    gss_core #(
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_kind   (r_in_kind),
        .i_f      (r_in_f),
        .i_lower  (w_lower),
        .i_upper  (w_upper),
        .i_tol    (w_tol),
        .i_limit  (w_limit),
        .o_status (w_status),
        .o_point  (w_point),
        .o_width  (w_width),
        .o_steps  (w_steps),
        .o_evals  (w_evals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_status.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_status.emit) begin
            r_out_kind  <= w_status.kind;
            r_out_point <= w_point;
            r_out_width <= w_width;
            r_out_steps <= w_steps;
            r_out_evals <= w_evals;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{(OUT_W-FIELDS_W){1'b0}}, r_out_evals, r_out_steps,
                         r_out_width, r_out_point};

endmodule

// File: rtl/gss_checker.sv
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks on the result stream of the line search controller.
// ----------------------------------------------------------------------------
`include "golden_section_line_search_top_macros.svh"

module gss_checker #(
    parameter int DATA_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [((2*DATA_WIDTH+2*COUNT_WIDTH+1+7)/8)*8-1:0] o_m_tdata,
    input logic                          o_m_tuser
);
    import gss_pkg::*;

    localparam int WID_LO  = DATA_WIDTH;
    localparam int STP_LO  = 2*DATA_WIDTH;
    localparam int EVL_LO  = 2*DATA_WIDTH + COUNT_WIDTH;
    localparam int EVL_HI  = EVL_LO + COUNT_WIDTH;

    logic [COUNT_WIDTH-1:0] w_steps;
    logic [COUNT_WIDTH:0]   w_evals;
    logic                   w_tail_zero;

    assign w_steps     = o_m_tdata[EVL_LO-1:STP_LO];
    assign w_evals     = o_m_tdata[EVL_HI:EVL_LO];
    assign w_tail_zero = (o_m_tdata[EVL_HI:WID_LO] == '0);

    // a stalled result transaction holds
    `GSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // probe requests carry no width or counts
    `GSS_ASSERT_HOLD(a_probe_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == RES_PROBE), w_tail_zero)

    // a final result always used two evaluations more than iterations
    `GSS_ASSERT_HOLD(a_final_evals, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == RES_FINAL), w_evals == ({1'b0, w_steps} + (COUNT_WIDTH+1)'(2)))

    // nothing is offered right after reset
    `GSS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_m_tvalid)

endmodule

bind golden_section_line_search_top gss_checker #(
    .DATA_WIDTH  (DATA_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_gss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: bench/tb_golden_section_line_search_top.sv
// ----------------------------------------------------------------------------
// tb_golden_section_line_search_top
// Self-checking bench for the golden-section line search controller: a short
// table of directed transactions, then random searches fed from synthetic
// objectives, every result checked against a bit-exact predictor or a typed value.
// ----------------------------------------------------------------------------
module tb_golden_section_line_search_top;
    import gss_pkg::*;

    localparam int RES_TDATA_W  = ((2*32 + 2*16 + 1 + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_CYC   = 4;

    typedef struct packed {
        logic        kind;
        logic [31:0] point;
        logic [31:0] width;
        logic [15:0] steps;
        logic [16:0] evals;
    } t_gss_result;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} t_check;
    typedef enum logic [1:0] {OBJ_NOISE, OBJ_BOWL, OBJ_HILL, OBJ_FLAT} t_objective;

    typedef struct packed {
        t_row_kind             op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [31:0]           value;
        logic                  req;
        t_check                chk;
        t_gss_result           res;
    } t_dir_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [31:0]            i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [31:0]            i_s_tdata   = '0;
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [RES_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;

    golden_section_line_search_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor copy of registers and search state
    logic signed [31:0] bound_a   = 32'sd0;
    logic signed [31:0] bound_b   = 32'sd65536;
    logic [30:0]        tol_q     = 31'd66;
    logic [15:0]        limit_q   = 16'd100;
    logic signed [31:0] lo_pt     = '0;
    logic signed [31:0] hi_pt     = '0;
    logic signed [31:0] probe_l   = '0;
    logic signed [31:0] probe_r   = '0;
    logic signed [31:0] val_l     = '0;
    logic signed [31:0] val_r     = '0;
    logic [15:0]        iter_cnt  = '0;
    logic [16:0]        eval_cnt  = '0;
    t_phase             search_phase = PH_IDLE;
    logic               await_side   = SIDE_LEFT;
    logic signed [31:0] probe_at     = '0;

    t_gss_result awaited_results[$];
    int          mismatch_count = 0;
    int          random_items   = 0;
    int          burst_left     = 0;
    int          idle_cycles    = 0;

    function automatic t_gss_result mk_result(logic kind, logic [31:0] point,
                                              logic [31:0] width, logic [15:0] steps,
                                              logic [16:0] evals);
        t_gss_result r;
        r.kind  = kind;
        r.point = point;
        r.width = width;
        r.steps = steps;
        r.evals = evals;
        return r;
    endfunction

    // floor(diff * psi), psi in Q0.32
    function automatic logic [32:0] golden_fraction(logic [32:0] diff);
        logic [64:0] prod;
        prod = {32'd0, diff} * {33'd0, PSI_Q32};
        return prod[64:32];
    endfunction

    function automatic logic [32:0] interval_span();
        return {hi_pt[31], hi_pt} - {lo_pt[31], lo_pt};
    endfunction

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_LOWER: bound_a = data;
            CFG_UPPER: bound_b = data;
            CFG_TOL:   tol_q   = data[30:0];
            CFG_LIMIT: limit_q = data[15:0];
            default: ;
        endcase
    endtask

    task automatic narrow_or_finish(output t_gss_result res);
        logic [32:0] d;
        logic [32:0] t;
        d = interval_span();
        if (iter_cnt == limit_q || d <= {1'b0, tol_q, 1'b0}) begin
            search_phase = PH_IDLE;
            res = mk_result(RES_FINAL, lo_pt + d[32:1], d[31:0], iter_cnt, eval_cnt);
        end else begin
            // equal values keep the low part of the interval
            if (val_l > val_r) begin
                lo_pt   = probe_l;
                probe_l = probe_r;
                val_l   = val_r;
                t       = golden_fraction(interval_span());
                probe_r = lo_pt + t[31:0];
                await_side = SIDE_RIGHT;
                res = mk_result(RES_PROBE, probe_r, '0, '0, '0);
            end else begin
                hi_pt   = probe_r;
                probe_r = probe_l;
                val_r   = val_l;
                t       = golden_fraction(interval_span());
                probe_l = hi_pt - t[31:0];
                await_side = SIDE_LEFT;
                res = mk_result(RES_PROBE, probe_l, '0, '0, '0);
            end
            search_phase = PH_ITER;
        end
    endtask

    task automatic predict_search(input logic req, input logic signed [31:0] f,
                                  output bit emits, output t_gss_result res);
        logic [32:0] t;
        emits = 1'b0;
        res   = '0;
        if (req == REQ_START) begin
            if (bound_a > bound_b) begin
                lo_pt = bound_b;
                hi_pt = bound_a;
            end else begin
                lo_pt = bound_a;
                hi_pt = bound_b;
            end
            t        = golden_fraction(interval_span());
            probe_l  = hi_pt - t[31:0];
            probe_r  = lo_pt + t[31:0];
            val_l    = '0;
            val_r    = '0;
            iter_cnt = '0;
            eval_cnt = '0;
            await_side   = SIDE_LEFT;
            search_phase = PH_FIRST;
            emits = 1'b1;
            res   = mk_result(RES_PROBE, probe_l, '0, '0, '0);
        end else begin
            case (search_phase)
                PH_FIRST: begin
                    val_l    = f;
                    eval_cnt = 17'd1;
                    search_phase = PH_SECOND;
                    emits = 1'b1;
                    res   = mk_result(RES_PROBE, probe_r, '0, '0, '0);
                end
                PH_SECOND: begin
                    val_r    = f;
                    eval_cnt = 17'd2;
                    emits    = 1'b1;
                    narrow_or_finish(res);
                end
                PH_ITER: begin
                    if (await_side == SIDE_RIGHT) val_r = f;
                    else val_l = f;
                    eval_cnt = eval_cnt + 17'd1;
                    iter_cnt = iter_cnt + 16'd1;
                    emits    = 1'b1;
                    narrow_or_finish(res);
                end
                default: ;  // value while idle is dropped
            endcase
        end
        if (emits && res.kind == RES_PROBE) probe_at = res.point;
    endtask

    // ---------------- driving ----------------

    task automatic sender_pause(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // wait until every awaited result has come, then let the pipeline settle
    task automatic drain();
        sender_pause(1);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            sender_pause($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 150);
            else burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_item(input logic req, input logic [31:0] f,
                             input t_check chk = CHK_MODEL, input t_gss_result typed = '0);
        bit          emits;
        t_gss_result res;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= f;
        do @(posedge i_clk); while (!o_s_tready);
        predict_search(req, f, emits, res);
        if (chk == CHK_TYPED) begin
            emits = 1'b1;
            res   = typed;
        end else if (chk == CHK_NONE) begin
            emits = 1'b0;
        end
        if (emits) awaited_results.push_back(res);
    endtask

    function automatic logic [31:0] objective_at(t_objective obj, logic signed [31:0] p,
                                                 logic signed [31:0] target,
                                                 logic [31:0] level);
        logic signed [32:0] gap;
        gap = (p >>> 1) - (target >>> 1);
        if (gap < 0) gap = -gap;
        case (obj)
            OBJ_BOWL: return gap[31:0];
            OBJ_HILL: return -gap[31:0];
            OBJ_FLAT: return level;
            default:  return $urandom;
        endcase
    endfunction

    task automatic configure_random();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] spread;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            lo = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
            spread = $urandom_range(0, 1) ? $urandom_range(0, 1 << 24)
                                          : $urandom_range(0, 4096);
            hi = lo + spread;
        end else if (pick < 17) begin
            lo = $urandom;
            hi = $urandom;
        end else begin
            lo = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            hi = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if ($urandom_range(0, 2) == 0) begin
            spread = lo;
            lo = hi;
            hi = spread;
        end
        if ($urandom_range(0, 4) != 0) begin
            cfg_write(CFG_LOWER, lo);
            cfg_write(CFG_UPPER, hi);
        end
        if ($urandom_range(0, 1) != 0) begin
            pick = $urandom_range(0, 9);
            cfg_write(CFG_TOL, (pick < 7) ? $urandom_range(0, 4096) :
                               (pick < 9) ? $urandom : 32'd0);
        end
        if ($urandom_range(0, 1) != 0) begin
            pick = $urandom_range(0, 9);
            cfg_write(CFG_LIMIT, (pick < 7) ? $urandom_range(0, 20) :
                                 (pick < 9) ? $urandom_range(21, 100) : $urandom);
        end
    endtask

    task automatic run_search_episode();
        t_objective         obj;
        logic signed [31:0] target;
        logic [31:0]        level;
        bit                 abandon;
        int                 r;
        if ($urandom_range(0, 3) != 0) configure_random();
        // stray values to an idle block
        if (search_phase == PH_IDLE && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                pace();
                push_item(REQ_VALUE, $urandom);
            end
        end
        obj    = t_objective'($urandom_range(0, 3));
        target = $urandom;
        level  = $urandom;
        pace();
        push_item(REQ_START, $urandom);
        random_items++;
        abandon = 1'b0;
        while (search_phase != PH_IDLE && !abandon) begin
            pace();
            r = $urandom_range(0, 99);
            if (r == 0) begin
                push_item(REQ_START, $urandom);
                random_items++;
            end else if (r == 1) begin
                abandon = 1'b1;
            end else begin
                if (r == 2) drain();
                push_item(REQ_VALUE, objective_at(obj, probe_at, target, level));
                random_items++;
            end
        end
    endtask

    function automatic t_dir_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        t_dir_row row;
        row       = '0;
        row.op    = ROW_CFG;
        row.idx   = idx;
        row.value = data;
        return row;
    endfunction

    function automatic t_dir_row item_row(logic req, logic [31:0] f,
                                          t_check chk = CHK_MODEL,
                                          t_gss_result res = '0);
        t_dir_row row;
        row       = '0;
        row.op    = ROW_ITEM;
        row.req   = req;
        row.value = f;
        row.chk   = chk;
        row.res   = res;
        return row;
    endfunction

    // ---------------- result side ----------------

    initial begin : sink_pattern
        int mode;
        int run_len;
        int tick;
        tick = 0;
        forever begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(20, 150);
            repeat (run_len) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= $urandom_range(0, 1);
                    2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_gss_result got;
        t_gss_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = mk_result(o_m_tuser, o_m_tdata[31:0], o_m_tdata[63:32],
                            o_m_tdata[79:64], o_m_tdata[96:80]);
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d point %h width %h steps %0d evals %0d",
                             got.kind, got.point, got.width, got.steps, got.evals);
            end else begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind || got.point !== want.point ||
                    got.width !== want.width || got.steps !== want.steps ||
                    got.evals !== want.evals) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp kind %0d point %h width %h steps %0d evals %0d",
                                 want.kind, want.point, want.width, want.steps, want.evals);
                        $display("          got kind %0d point %h width %h steps %0d evals %0d",
                                 got.kind, got.point, got.width, got.steps, got.evals);
                    end
                end
            end
        end
    end

    // no transaction on any channel for too long means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    initial begin : stimulus
        t_dir_row dir_rows[$];
        int       waited;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            item_row(REQ_VALUE, 32'h7FFF_FFFF, CHK_NONE),
            item_row(REQ_START, 32'hFFFF_FFFF, CHK_TYPED,
                     mk_result(RES_PROBE, 32'd25033, '0, '0, '0)),
            item_row(REQ_VALUE, 32'd100, CHK_TYPED,
                     mk_result(RES_PROBE, 32'd40503, '0, '0, '0)),
            item_row(REQ_VALUE, 32'd200),
            // restart in the middle of a search
            item_row(REQ_START, 32'd0, CHK_TYPED,
                     mk_result(RES_PROBE, 32'd25033, '0, '0, '0)),
            cfg_row(CFG_LIMIT, 32'd0),
            item_row(REQ_START, 32'h5A5A_5A5A, CHK_TYPED,
                     mk_result(RES_PROBE, 32'd25033, '0, '0, '0)),
            item_row(REQ_VALUE, 32'h8000_0000, CHK_TYPED,
                     mk_result(RES_PROBE, 32'd40503, '0, '0, '0)),
            item_row(REQ_VALUE, 32'h7FFF_FFFF, CHK_TYPED,
                     mk_result(RES_FINAL, 32'd32768, 32'd65536, 16'd0, 17'd2)),
            // widest interval, given reversed
            cfg_row(CFG_LOWER, 32'h7FFF_FFFF),
            cfg_row(CFG_UPPER, 32'h8000_0000),
            cfg_row(CFG_TOL, 32'd0),
            cfg_row(CFG_LIMIT, 32'd3),
            item_row(REQ_START, 32'h0000_0000),
            item_row(REQ_VALUE, 32'd5),
            item_row(REQ_VALUE, 32'd5),
            item_row(REQ_VALUE, 32'd1),
            item_row(REQ_VALUE, 32'd7),
            item_row(REQ_VALUE, 32'd3),
            item_row(REQ_START, 32'hA5A5_A5A5),
            item_row(REQ_VALUE, 32'hFFFF_FFFF),
            // registers changed while the search waits for a value
            cfg_row(CFG_TOL, 32'hFFFF_FFFF),
            cfg_row(CFG_LIMIT, 32'h0000_FFFF),
            item_row(REQ_VALUE, 32'h0000_0000),
            item_row(REQ_VALUE, 32'h1234_5678),
            item_row(REQ_VALUE, 32'd0, CHK_NONE)
        };

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                cfg_write(dir_rows[i].idx, dir_rows[i].value);
            end else begin
                pace();
                push_item(dir_rows[i].req, dir_rows[i].value, dir_rows[i].chk, dir_rows[i].res);
            end
        end

        while (random_items < RANDOM_ITEMS) run_search_episode();

        sender_pause(1);
        waited = 0;
        while (awaited_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8 * SETTLE_CYC) @(posedge i_clk);
        if (awaited_results.size() != 0)
            $display("results never delivered: %0d", awaited_results.size());

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
